@@ rtl/ring_deque_with_search_unit_assert.svh @@
// Assertion macros shared by the deque modules.
`ifndef RING_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define RING_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTH
// Check prop at every rising edge once reset is released.
`define RDQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("deque assertion failed");
// Check that cond never holds once reset is released.
`define RDQ_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("deque forbidden condition seen");
`else
`define RDQ_ASSERT(label, clk, rst_n, prop)
`define RDQ_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ rtl/rdq_pkg.sv @@
package rdq_pkg;

    localparam int QDEPTH = 2;

    // input command codes
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_SEARCH,
        OP_NOP
    } t_op_kind;

    typedef struct packed {
        t_op_kind           kind;
        logic signed [31:0] value;
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_POP,
        BS_SRCH
    } t_bstate;

endpackage

@@ rtl/ring_deque_with_search_unit.sv @@
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// command  | in        | i_valid / o_stall  | i_command, i_value
// result   | out       | o_valid / i_stall  | o_status, o_result_value, o_position, o_count
//
// Push, no-op and any refused or empty-store command load the result on the take;
// pop waits for one memory read; search compares one stored entry per cycle through the
// single read port of the ring memory, until a hit or after the last entry.
// A two-entry command queue registers each transaction and holds up to two
// transactions while a result waits on i_stall, then raises o_stall.
// i_rst_n (synchronous, active low) clears pointers and handshake state only.
module ring_deque_with_search_unit
    import rdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic [3:0]         o_position,
    output logic [4:0]         o_count
);

    // decoded transactions waiting for the back end
    logic q_valid;
    logic q_take;
    t_op  q_op;

    // Front end: accept and decode the command, hold it in the short queue.
    rdq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .i_value   (i_value),
        .o_q_valid (q_valid),
        .o_q       (q_op),
        .i_q_take  (q_take)
    );

    // Back end: own the ring and pointers, run the search scan, drive the
    // result register. Take a new transaction only when the result slot frees.
    rdq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q            (q_op),
        .o_q_take       (q_take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_position     (o_position),
        .o_count        (o_count)
    );

endmodule

@@ rtl/rdq_front.sv @@
`include "ring_deque_with_search_unit_assert.svh"

module rdq_front
    import rdq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_value,
    output logic               o_q_valid,
    output t_op                o_q,
    input  logic               i_q_take
);

    t_op        r_buf [QDEPTH];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_op        dec_op;
    logic       acc;

    // classify the command; unused codes become a no-op
    always_comb begin
        dec_op.value = i_value;
        unique case (i_command)
            CMD_PUSH_FRONT: dec_op.kind = OP_PUSH_FRONT;
            CMD_PUSH_BACK:  dec_op.kind = OP_PUSH_BACK;
            CMD_POP_FRONT:  dec_op.kind = OP_POP_FRONT;
            CMD_POP_BACK:   dec_op.kind = OP_POP_BACK;
            CMD_SEARCH:     dec_op.kind = OP_SEARCH;
            default:        dec_op.kind = OP_NOP;
        endcase
    end

    assign o_stall   = (r_cnt == 2'(QDEPTH));
    assign acc       = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q       = r_buf[r_rp];

    always_comb begin
        n_wp  = acc ? ~r_wp : r_wp;
        n_rp  = i_q_take ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(acc) - 2'(i_q_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_buf[r_wp] <= dec_op;
        end
    end

    `RDQ_NEVER(a_fifo_over, i_clk, i_rst_n, r_cnt > 2'(QDEPTH))
    `RDQ_NEVER(a_take_empty, i_clk, i_rst_n, i_q_take && (r_cnt == 2'd0))
    `RDQ_ASSERT(a_fill, i_clk, i_rst_n, (acc && !i_q_take) |=> (r_cnt == $past(r_cnt) + 2'd1))

endmodule

@@ rtl/rdq_back.sv @@
`include "ring_deque_with_search_unit_assert.svh"

module rdq_back
    import rdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_op                i_q,
    output logic               o_q_take,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic [3:0]         o_position,
    output logic [4:0]         o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]    r_mem [DEPTH];
    logic [31:0]    r_rd_data;
    logic [AW-1:0]  rd_addr;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;

    t_bstate        r_state, n_state;
    logic [AW-1:0]  r_front, n_front;
    logic [CW-1:0]  r_count, n_count;
    logic [31:0]    r_key, n_key;
    logic [CW-1:0]  r_off_nxt, n_off_nxt;
    logic [CW-1:0]  r_left, n_left;
    logic           r_cmp_vld, n_cmp_vld;
    logic [CW-1:0]  r_cmp_off, n_cmp_off;
    logic           r_cmp_last, n_cmp_last;

    logic           r_ovalid;
    t_status        r_status, res_status;
    logic [31:0]    r_rval, res_rval;
    logic [CW-1:0]  r_pos, res_pos;
    logic [CW-1:0]  r_ocnt, res_cnt;
    logic           load_res;

    logic           out_free, start, full, empty, hit, miss;
    logic [AW-1:0]  front_dec, front_inc;
    logic [CW+3:0]  pos_ext;
    logic [CW+4:0]  cnt_ext;

    // ring slot of an offset from the front; the sum stays below twice DEPTH
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] fr,
                                             input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(fr) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign out_free  = !r_ovalid || !i_stall;
    assign start     = (r_state == BS_IDLE) && i_q_valid && out_free;
    assign o_q_take  = start;
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign hit       = r_cmp_vld && (r_rd_data == r_key);
    assign miss      = r_cmp_vld && r_cmp_last && !hit;
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (start && !empty) begin
                    if (i_q.kind == OP_POP_FRONT || i_q.kind == OP_POP_BACK) begin
                        n_state = BS_POP;
                    end else if (i_q.kind == OP_SEARCH) begin
                        n_state = BS_SRCH;
                    end
                end
            end
            BS_POP:  n_state = BS_IDLE;
            BS_SRCH: begin
                if (hit || miss) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_front    = r_front;
        n_count    = r_count;
        n_key      = r_key;
        n_off_nxt  = r_off_nxt;
        n_left     = r_left;
        n_cmp_vld  = 1'b0;
        n_cmp_off  = r_cmp_off;
        n_cmp_last = r_cmp_last;
        rd_addr    = r_front;
        mem_we     = 1'b0;
        mem_wa     = r_front;
        load_res   = 1'b0;
        res_status = ST_OK;
        res_rval   = '0;
        res_pos    = '0;
        res_cnt    = r_count;
        unique case (r_state)
            BS_IDLE: begin
                if (start) begin
                    unique case (i_q.kind)
                        OP_PUSH_FRONT: begin
                            load_res = 1'b1;
                            if (full) begin
                                res_status = ST_FULL;
                            end else begin
                                n_front = front_dec;
                                mem_we  = 1'b1;
                                mem_wa  = front_dec;
                                n_count = r_count + CW'(1);
                                res_cnt = n_count;
                            end
                        end
                        OP_PUSH_BACK: begin
                            load_res = 1'b1;
                            if (full) begin
                                res_status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                mem_wa  = f_slot(r_front, r_count);
                                n_count = r_count + CW'(1);
                                res_cnt = n_count;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                load_res   = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                rd_addr = r_front;
                                n_front = front_inc;
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                load_res   = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                rd_addr = f_slot(r_front, r_count - CW'(1));
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_SEARCH: begin
                            if (empty) begin
                                load_res   = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                // back entry goes first, then front toward back
                                rd_addr    = f_slot(r_front, r_count - CW'(1));
                                n_key      = i_q.value;
                                n_cmp_vld  = 1'b1;
                                n_cmp_off  = r_count - CW'(1);
                                n_cmp_last = (r_count == CW'(1));
                                n_left     = r_count - CW'(1);
                                n_off_nxt  = '0;
                            end
                        end
                        default: begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            BS_POP: begin
                load_res = 1'b1;
                res_rval = r_rd_data;
            end
            BS_SRCH: begin
                if (hit) begin
                    load_res = 1'b1;
                    res_rval = r_key;
                    res_pos  = r_cmp_off;
                end else if (miss) begin
                    load_res   = 1'b1;
                    res_status = ST_NOTFOUND;
                end else begin
                    // issue the next read while comparing the previous one
                    rd_addr    = f_slot(r_front, r_off_nxt);
                    n_cmp_vld  = 1'b1;
                    n_cmp_off  = r_off_nxt;
                    n_cmp_last = (r_left == CW'(1));
                    n_off_nxt  = r_off_nxt + CW'(1);
                    n_left     = r_left - CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            if (load_res) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_off_nxt  <= n_off_nxt;
        r_left     <= n_left;
        r_cmp_off  <= n_cmp_off;
        r_cmp_last <= n_cmp_last;
        if (load_res) begin
            r_status <= res_status;
            r_rval   <= res_rval;
            r_pos    <= res_pos;
            r_ocnt   <= res_cnt;
        end
    end

    // ring storage, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= i_q.value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign pos_ext        = {4'b0, r_pos};
    assign cnt_ext        = {5'b0, r_ocnt};
    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_result_value = r_rval;
    assign o_position     = pos_ext[3:0];
    assign o_count        = cnt_ext[4:0];

    `RDQ_NEVER(a_count_over, i_clk, i_rst_n, r_count > CW'(DEPTH))
    `RDQ_ASSERT(a_res_free, i_clk, i_rst_n, load_res |-> (!r_ovalid || !i_stall))
    `RDQ_ASSERT(a_pop_after_take, i_clk, i_rst_n, (r_state == BS_POP) |-> $past(o_q_take))

endmodule

@@ tb/deque_result_checker.sv @@
module deque_result_checker
    import rdq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  logic               i_cmd_stall,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_value,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [1:0]         i_status,
    input  logic signed [31:0] i_result_value,
    input  logic [3:0]         i_position,
    input  logic [4:0]         i_count,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SIZE = 16;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] value;
        logic [3:0]         position;
        logic [4:0]         count;
    } deque_result_t;

    // shadow copy of the deque; 4-bit slots wrap around the 16-entry ring
    logic signed [31:0] ring_mem [RING_SIZE];
    logic [3:0]         head_slot;
    logic [4:0]         fill_level;

    deque_result_t expected_results [$];

    // Update the shadow deque for one command and return the result it must produce.
    function automatic deque_result_t apply_deque_command(input logic [2:0] cmd,
                                                          input logic signed [31:0] val);
        deque_result_t res;
        logic [3:0]    back_slot;
        res.status   = ST_OK;
        res.value    = '0;
        res.position = '0;
        back_slot    = head_slot + 4'(fill_level - 5'd1);
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (fill_level >= RING_SIZE) begin
                    res.status = ST_FULL;
                end else begin
                    head_slot           = head_slot - 4'd1;
                    ring_mem[head_slot] = val;
                    fill_level          = fill_level + 5'd1;
                end
            end
            CMD_PUSH_BACK: begin
                if (fill_level >= RING_SIZE) begin
                    res.status = ST_FULL;
                end else begin
                    ring_mem[head_slot + 4'(fill_level)] = val;
                    fill_level = fill_level + 5'd1;
                end
            end
            CMD_POP_FRONT: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value  = ring_mem[head_slot];
                    head_slot  = head_slot + 4'd1;
                    fill_level = fill_level - 5'd1;
                end
            end
            CMD_POP_BACK: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value  = ring_mem[back_slot];
                    fill_level = fill_level - 5'd1;
                end
            end
            CMD_SEARCH: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else if (ring_mem[back_slot] == val) begin
                    res.value    = val;
                    res.position = 4'(fill_level - 5'd1);
                end else begin
                    res.status = ST_NOTFOUND;
                    // walk downward so the match nearest the front is the one kept
                    for (int i = int'(fill_level) - 2; i >= 0; i--) begin
                        if (ring_mem[head_slot + 4'(i)] == val) begin
                            res.status   = ST_OK;
                            res.value    = val;
                            res.position = 4'(i);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = fill_level;
        return res;
    endfunction

    always @(posedge i_clk) begin
        deque_result_t want;
        if (!i_rst_n) begin
            head_slot    = '0;
            fill_level   = '0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            // compare before queuing: a transaction taken at this edge cannot have answered yet
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result with nothing outstanding: status %0d value %0d",
                                 $realtime, i_status, i_result_value);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_status || want.value !== i_result_value ||
                        want.position !== i_position || want.count !== i_count) begin
                        // each pair reads expected/actual
                        if (o_fail_count < 10)
                            $display("%0t: status %0d/%0d value %0d/%0d pos %0d/%0d count %0d/%0d",
                                     $realtime, want.status, i_status,
                                     want.value, i_result_value,
                                     want.position, i_position, want.count, i_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_cmd_valid && !i_cmd_stall)
                expected_results.push_back(apply_deque_command(i_command, i_value));
        end
        o_pending = expected_results.size();
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rdq_pkg::*;

    // Hard stop for a hung run; a correct run needs a small fraction of this.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 1800;
    // Highest of the command codes the block treats as a no-op.
    localparam logic [2:0] CMD_RESERVED = 3'd7;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_command;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_result_value;
    logic [3:0]         o_position;
    logic [4:0]         o_count;

    int          fail_count;
    int          pending;
    int          idle_pct;   // chance per cycle that the sender holds off
    int          stall_pct;  // chance per cycle that the receiver stalls
    int unsigned cycle_count = 0;

    ring_deque_with_search_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_position     (o_position),
        .o_count        (o_count)
    );

    // The checker watches both channels and does all prediction and comparison.
    deque_result_checker u_result_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_valid),
        .i_cmd_stall    (o_stall),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_status       (o_status),
        .i_result_value (o_result_value),
        .i_position     (o_position),
        .i_count        (o_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Count cycles and give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver side: redraw the stall every falling edge from the current phase's rate.
    always @(negedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Draw a data word. Most come from a small pool so that equal entries pile up
    // in the deque and searches hit, often more than once; the rest are fully random.
    function automatic logic signed [31:0] draw_value();
        case ($urandom_range(11))
            0: return 32'sd0;
            1: return -32'sd1;
            2: return 32'sd1;
            3: return 32'sh7FFF_FFFF;
            4: return 32'sh8000_0000;
            5: return 32'sh5555_5555;
            6: return 32'shAAAA_AAAA;
            7: return 32'sd7;
            default: return $urandom();
        endcase
    endfunction

    // Send one command transaction. Called at a falling edge; returns at the falling
    // edge after the transaction is taken. Valid stays high into the next call, so
    // back-to-back transactions never lower and raise it within one step.
    task automatic issue_command(input logic [2:0] cmd, input logic signed [31:0] val);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int         roll;
        int         push_pct;
        logic [2:0] cmd;

        idle_pct    = 0;
        stall_pct   = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = CMD_PUSH_FRONT;
        i_value     = '0;

        // Hold reset low, then release it away from the sampling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, no idling on either side.
        // Pops and search on an empty deque.
        issue_command(CMD_POP_FRONT, 32'sd0);
        issue_command(CMD_POP_BACK, -32'sd1);
        issue_command(CMD_SEARCH, 32'sd5);
        // Extremes of the value range at both ends: deque becomes -1, max, min, 0.
        issue_command(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        issue_command(CMD_PUSH_BACK, 32'sh8000_0000);
        issue_command(CMD_PUSH_FRONT, -32'sd1);
        issue_command(CMD_PUSH_BACK, 32'sd0);
        // Search hitting the back entry, one found on the front walk, and a miss.
        issue_command(CMD_SEARCH, 32'sd0);
        issue_command(CMD_SEARCH, 32'sh7FFF_FFFF);
        issue_command(CMD_SEARCH, 32'sd12345);
        // An unused command code leaves the deque alone.
        issue_command(CMD_RESERVED, 32'sh5A5A_5A5A);
        // Fill to capacity from both ends, then push at both ends of a full deque.
        for (int k = 0; k < 12; k++)
            issue_command(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom());
        issue_command(CMD_PUSH_FRONT, 32'sd99);
        issue_command(CMD_PUSH_BACK, 32'sd99);
        wait_for_results();

        // Random part in four idling phases: none, sender idle, receiver stalling, both.
        // Each phase drains completely before the next, so the sender pauses until
        // nothing is outstanding.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 80;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 80;
                end
                default: begin
                    idle_pct  = 21;
                    stall_pct = 21;
                end
            endcase
            push_pct = 45;
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                // Switch between filling, draining and mixed runs so the deque keeps
                // crossing from empty to full and back.
                if (n % 40 == 0) begin
                    case ($urandom_range(2))
                        0: push_pct = 70;
                        1: push_pct = 20;
                        default: push_pct = 45;
                    endcase
                end
                roll = $urandom_range(99);
                if (roll < push_pct)
                    cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else if (roll < push_pct + 15)
                    cmd = CMD_SEARCH;
                else if (roll < 97)
                    cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
                else
                    cmd = 3'($urandom_range(CMD_RESERVED, CMD_SEARCH + 1));
                issue_command(cmd, draw_value());
            end
            wait_for_results();
        end

        // Let any stray late result show up before the verdict.
        idle_pct  = 0;
        stall_pct = 0;
        repeat (40) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rdq_pkg.sv
rtl/rdq_front.sv
rtl/rdq_back.sv
rtl/ring_deque_with_search_unit.sv
tb/deque_result_checker.sv
tb/testbench.sv
